[sv/mdi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mdi_pkg: shared types and constants of the deadline interpolator
// value and time widths, defaults and the request/response of the mul-div unit
// ----------------------------------------------------------------------------
package mdi_pkg;

	localparam int VAL_W        = 32;
	localparam int TIME_W       = 48;
	localparam int CFG_W        = 16;
	localparam int CHANNELS_DEF = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd150;

	// request kinds carried in the slave-side tuser
	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_VECTOR = 2'd1,
		ACT_RESET  = 2'd2,
		ACT_UNUSED = 2'd3
	} mdi_action_t;

	// request to the shared multiply-divide unit: floor(mag * dt / den)
	typedef struct packed {
		logic              valid;
		logic [VAL_W-1:0]  mag;
		logic [TIME_W-1:0] dt;
		logic [TIME_W-1:0] den;
	} mdi_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quo;
	} mdi_rsp_t;

endpackage
`default_nettype wire

[sv/mdi_muldiv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mdi_muldiv: shared iterative multiply-divide unit
// product of a 32 bit magnitude and 48 bit time in two half multiplies,
// then a 32 step restoring division; quotient is known to fit 32 bits
// ----------------------------------------------------------------------------
module mdi_muldiv import mdi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mdi_req_t req,
	output mdi_rsp_t      rsp
);

	localparam int HALF_W = TIME_W / 2;
	localparam int PP_W   = VAL_W + HALF_W;
	localparam int PROD_W = VAL_W + TIME_W;
	localparam int CNT_W  = $clog2(VAL_W);

	typedef enum logic [2:0] {MD_IDLE, MD_MLO, MD_MHI, MD_ADD, MD_DIV} md_state_t;

	md_state_t          state_q;
	logic [VAL_W-1:0]   mag_q;
	logic [TIME_W-1:0]  dt_q;
	logic [TIME_W-1:0]  den_q;
	logic [PP_W-1:0]    lo_q;
	logic [PP_W-1:0]    hi_q;
	logic [TIME_W-1:0]  rem_q;
	logic [VAL_W-1:0]   qsh_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;

	logic [HALF_W-1:0]  mul_b;
	logic [PP_W-1:0]    pp;
	logic [PROD_W-1:0]  prod;
	logic [TIME_W:0]    trial;
	logic [TIME_W:0]    diff;
	logic               ge;

	assign mul_b = (state_q == MD_MLO) ? dt_q[HALF_W-1:0] : dt_q[TIME_W-1:HALF_W];
	assign pp    = PP_W'(mag_q) * PP_W'(mul_b);
	assign prod  = {hi_q, {HALF_W{1'b0}}} + PROD_W'(lo_q);
	assign trial = {rem_q, qsh_q[VAL_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (req.valid) begin
						mag_q   <= req.mag;
						dt_q    <= req.dt;
						den_q   <= req.den;
						state_q <= MD_MLO;
					end
				end
				MD_MLO: begin
					lo_q    <= pp;
					state_q <= MD_MHI;
				end
				MD_MHI: begin
					hi_q    <= pp;
					state_q <= MD_ADD;
				end
				MD_ADD: begin
					// upper part is already below the divisor
					rem_q   <= prod[PROD_W-1:VAL_W];
					qsh_q   <= prod[VAL_W-1:0];
					cnt_q   <= '0;
					state_q <= MD_DIV;
				end
				MD_DIV: begin
					rem_q <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
					qsh_q <= {qsh_q[VAL_W-2:0], ge};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(VAL_W - 1)) begin
						done_q  <= 1'b1;
						state_q <= MD_IDLE;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = qsh_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MD_DIV |-> rem_q < den_q)
		else $error("division remainder not below divisor");

	a_req_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> state_q == MD_IDLE)
		else $error("mul-div request while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held longer than one cycle");

endmodule
`default_nettype wire

[sv/multichannel_deadline_interpolator.sv]
// a tick or later vector, once primed, visits each channel in turn through ST_CHK and ST_TGT;
// a channel that is moving also waits on the 32 step shared divider and passes ST_UPD,
// a channel at rest goes straight on; priming, reset and the unused action visit no channel
// throughput: one request at a time, the next accepted once the block is idle again
// reset: arst_n clears each channel's value, goal, error and deadline, primed and the last time, window back to 150
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_deadline_interpolator
// per-channel linear move of Q16.16 outputs toward targets by a deadline,
// channels served one after another by a shared multiply-divide unit
// ----------------------------------------------------------------------------
module multichannel_deadline_interpolator import mdi_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [CFG_W-1:0]                 cfg_wr_data,   // window_ms
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [TIME_W+VAL_W*CHANNELS-1:0] s_tdata,       // now_ms, target_0 ..
	input  wire logic [1:0]                       s_tuser,       // action
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [VAL_W*CHANNELS-1:0]             m_tdata,       // value_0 ..
	output logic [0:0]                            m_tuser        // primed
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_START, ST_CHK, ST_WAIT, ST_UPD, ST_TGT, ST_OUT
	} state_t;

	state_t             state_q;
	logic [1:0]         act_q;
	logic [TIME_W-1:0]  now_q;
	logic [VAL_W-1:0]   tgt_q  [CHANNELS];
	logic [VAL_W-1:0]   cur_q  [CHANNELS];
	logic [VAL_W-1:0]   goal_q [CHANNELS];
	logic [VAL_W-1:0]   err_q  [CHANNELS];
	logic [TIME_W-1:0]  arr_q  [CHANNELS];
	logic [TIME_W-1:0]  last_q;
	logic [TIME_W-1:0]  dt_q;
	logic [TIME_W-1:0]  base_q;
	logic [CFG_W-1:0]   window_q;
	logic               primed_q;
	logic               moved_q;
	logic [CH_W-1:0]    ch_q;

	mdi_req_t           md_req;
	mdi_rsp_t           md_rsp;

	logic [VAL_W-1:0]   cur_c, goal_c, err_c, tgt_c, mag_c;
	logic [TIME_W-1:0]  arr_c;
	logic               arrived_c, reached_c, changed_c;
	logic [VAL_W+1:0]   step_c, sum_c, diff_c;
	logic [VAL_W-1:0]   cur_new, err_new, diff_op;
	logic [TIME_W:0]    dl_c;
	logic [TIME_W-1:0]  arr_new;
	logic               any_arr;

	function automatic logic [VAL_W-1:0] sat32(input logic [VAL_W+1:0] v);
		logic [VAL_W-1:0] r;
		if (v[VAL_W+1:VAL_W-1] == 3'b000 || v[VAL_W+1:VAL_W-1] == 3'b111) begin
			r = v[VAL_W-1:0];
		end else if (v[VAL_W+1]) begin
			r = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VAL_W-1){1'b1}}};
		end
		return r;
	endfunction

	assign cur_c  = cur_q[ch_q];
	assign goal_c = goal_q[ch_q];
	assign err_c  = err_q[ch_q];
	assign tgt_c  = tgt_q[ch_q];
	assign arr_c  = arr_q[ch_q];

	assign arrived_c = (arr_c == '0);
	assign reached_c = (now_q >= arr_c);
	assign mag_c     = err_c[VAL_W-1] ? (~err_c + VAL_W'(1)) : err_c;

	// left + dt is the deadline minus the previous advance time, or minus now if time went back
	assign md_req.valid = (state_q == ST_CHK) && !arrived_c && !reached_c;
	assign md_req.mag   = mag_c;
	assign md_req.dt    = dt_q;
	assign md_req.den   = arr_c - base_q;

	mdi_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign step_c  = err_c[VAL_W-1] ? -{2'b00, md_rsp.quo} : {2'b00, md_rsp.quo};
	assign sum_c   = {{2{cur_c[VAL_W-1]}}, cur_c} + step_c;
	assign cur_new = sat32(sum_c);

	assign changed_c = (act_q == ACT_VECTOR) && (tgt_c != goal_c);
	assign diff_op   = changed_c ? tgt_c : goal_c;
	assign diff_c    = {{2{diff_op[VAL_W-1]}}, diff_op} - {{2{cur_c[VAL_W-1]}}, cur_c};
	assign err_new   = sat32(diff_c);
	assign dl_c      = {1'b0, now_q} + (TIME_W+1)'(window_q);
	assign arr_new   = dl_c[TIME_W] ? {TIME_W{1'b1}} : dl_c[TIME_W-1:0];

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		any_arr = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			any_arr = any_arr | (arr_q[i] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			primed_q <= 1'b0;
			last_q   <= '0;
			window_q <= WINDOW_RESET;
			moved_q  <= 1'b0;
			ch_q     <= '0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i]  <= '0;
				goal_q[i] <= '0;
				err_q[i]  <= '0;
				arr_q[i]  <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						act_q <= s_tuser;
						now_q <= s_tdata[TIME_W-1:0];
						for (int i = 0; i < CHANNELS; i++) begin
							tgt_q[i] <= s_tdata[TIME_W + i*VAL_W +: VAL_W];
						end
						state_q <= ST_START;
					end
				end
				ST_START: begin
					ch_q    <= '0;
					state_q <= ST_OUT;
					case (act_q)
						ACT_TICK, ACT_VECTOR: begin
							if (primed_q) begin
								// time going backwards counts as no elapsed time
								dt_q    <= (now_q > last_q) ? now_q - last_q : '0;
								base_q  <= (now_q > last_q) ? last_q : now_q;
								last_q  <= now_q;
								state_q <= ST_CHK;
							end else if (act_q == ACT_VECTOR) begin
								for (int i = 0; i < CHANNELS; i++) begin
									cur_q[i]  <= tgt_q[i];
									goal_q[i] <= tgt_q[i];
									err_q[i]  <= '0;
									arr_q[i]  <= '0;
								end
								last_q   <= now_q;
								primed_q <= 1'b1;
							end
						end
						ACT_RESET: begin
							primed_q <= 1'b0;
							for (int i = 0; i < CHANNELS; i++) begin
								arr_q[i] <= '0;
							end
						end
						default: ;
					endcase
				end
				ST_CHK: begin
					moved_q <= 1'b0;
					if (arrived_c) begin
						state_q <= ST_TGT;
					end else if (reached_c) begin
						// deadline reached: land exactly on the goal
						cur_q[ch_q] <= goal_c;
						err_q[ch_q] <= '0;
						arr_q[ch_q] <= '0;
						state_q     <= ST_TGT;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (md_rsp.done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					cur_q[ch_q] <= cur_new;
					moved_q     <= 1'b1;
					state_q     <= ST_TGT;
				end
				ST_TGT: begin
					if (changed_c) begin
						goal_q[ch_q] <= tgt_c;
						if (window_q == '0) begin
							cur_q[ch_q] <= tgt_c;
							err_q[ch_q] <= '0;
							arr_q[ch_q] <= '0;
						end else begin
							err_q[ch_q] <= err_new;
							arr_q[ch_q] <= arr_new;
						end
					end else if (moved_q) begin
						err_q[ch_q] <= err_new;
					end
					if (ch_q == CH_W'(CHANNELS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= ST_CHK;
					end
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						for (int i = 0; i < CHANNELS; i++) begin
							m_tdata[i*VAL_W +: VAL_W] <= cur_q[i];
						end
						m_tuser  <= primed_q;
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while a previous one is in progress");

	a_unprimed_at_rest: assert property (@(posedge clk) disable iff (!arst_n)
		!primed_q |-> !any_arr)
		else $error("deadline pending while not primed");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");

	a_wait_has_unit: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> state_q == ST_WAIT)
		else $error("divider finished with nobody waiting");

endmodule
`default_nettype wire

[dv/multichannel_deadline_interpolator_tb.sv]
// ----------------------------------------------------------------------------
// multichannel_deadline_interpolator_tb
// drives tick, target vector, reset and unused requests into the interpolator
// under random stalls on both streams, predicts every channel value in the
// bench and compares each response field by field to it or to a directed row
// ----------------------------------------------------------------------------
module multichannel_deadline_interpolator_tb import mdi_pkg::*; ();

	localparam int CH = CHANNELS_DEF;
	localparam int VW = VAL_W * CH;
	localparam logic [TIME_W-1:0] TIME_TOP = '1;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS = 100;
	localparam int LONG_HOLD = 1500;

	typedef struct packed {
		logic          primed;
		logic [VW-1:0] values;
	} result_t;

	typedef struct packed {
		logic              is_cfg;
		logic [CFG_W-1:0]  cfg_val;
		mdi_action_t       act;
		logic [TIME_W-1:0] now;
		logic [VW-1:0]     targets;
		logic              checked;
		logic              exp_primed;
		logic [VW-1:0]     exp_values;
	} row_t;

	// target sets, channel 6 first
	localparam logic [VW-1:0] VEC_PRIME = {32'hffff0000, 32'h12345678, 32'hffffffff,
		32'h00000001, 32'h00000000, 32'h80000000, 32'h7fffffff};
	localparam logic [VW-1:0] VEC_SWING = {32'h00000007, 32'hedcba988, 32'hffffffff,
		32'h00000001, 32'h00640000, 32'h7fffffff, 32'h80000000};
	localparam logic [VW-1:0] VEC_SNAP = {32'h00000000, 32'hf0f0f0f0, 32'h0f0f0f0f,
		32'haaaaaaaa, 32'h55555555, 32'hfffe0000, 32'h00010000};
	localparam logic [VW-1:0] VEC_LATE = {32'h3c3c3c3c, 32'h0f0f0f0f, 32'hf0f0f0f0,
		32'h55555555, 32'haaaaaaaa, 32'h80000000, 32'h7fffffff};
	localparam logic [VW-1:0] VEC_REPRIME = {32'h01234567, 32'h80000001, 32'h7ffffffe,
		32'hffff8000, 32'h00008000, 32'hdeadbeef, 32'h00000000};
	localparam logic [VW-1:0] VEC_MIN_WIN = {32'h01234567, 32'h7fffffff, 32'h80000000,
		32'hffff8000, 32'hffffffff, 32'hdeadbeef, 32'h40000000};

	localparam row_t DIRECTED [24] = '{
		// tick, reset and unused request before priming leave everything at zero
		'{1'b0, 16'd0, ACT_TICK,   48'd0,   '0,         1'b1, 1'b0, '0},
		'{1'b0, 16'd0, ACT_RESET,  48'd0,   '0,         1'b1, 1'b0, '0},
		'{1'b0, 16'd0, ACT_UNUSED, 48'd5,   '0,         1'b1, 1'b0, '0},
		'{1'b0, 16'd0, ACT_VECTOR, 48'd100, VEC_PRIME,  1'b1, 1'b1, VEC_PRIME},
		'{1'b0, 16'd0, ACT_TICK,   48'd150, '0,         1'b1, 1'b1, VEC_PRIME},
		// full-scale swings saturate the error
		'{1'b0, 16'd0, ACT_VECTOR, 48'd200, VEC_SWING,  1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_TICK,   48'd250, '0,         1'b0, 1'b0, '0},
		// time going backwards
		'{1'b0, 16'd0, ACT_TICK,   48'd240, '0,         1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_TICK,   48'd300, '0,         1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_UNUSED, 48'd320, '0,         1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_TICK,   48'd400, '0,         1'b1, 1'b1, VEC_SWING},
		// zero window snaps at once
		'{1'b1, 16'd0, ACT_TICK,   48'd0,   '0,         1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_VECTOR, 48'd500, VEC_SNAP,   1'b1, 1'b1, VEC_SNAP},
		// deadline clamped at the top of the time range
		'{1'b1, 16'hffff, ACT_TICK, 48'd0,  '0,         1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_VECTOR, TIME_TOP - 48'd10, VEC_LATE, 1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_TICK,   TIME_TOP - 48'd5,  '0,       1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_TICK,   TIME_TOP, '0,        1'b1, 1'b1, VEC_LATE},
		// reset keeps values, next vector primes again
		'{1'b0, 16'd0, ACT_RESET,  TIME_TOP, '0,        1'b1, 1'b0, VEC_LATE},
		'{1'b0, 16'd0, ACT_TICK,   48'd0,   '0,         1'b1, 1'b0, VEC_LATE},
		'{1'b0, 16'd0, ACT_VECTOR, 48'd10,  VEC_REPRIME, 1'b1, 1'b1, VEC_REPRIME},
		'{1'b1, 16'd1, ACT_TICK,   48'd0,   '0,         1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_VECTOR, 48'd20,  VEC_MIN_WIN, 1'b0, 1'b0, '0},
		'{1'b0, 16'd0, ACT_TICK,   48'd21,  '0,         1'b1, 1'b1, VEC_MIN_WIN},
		'{1'b1, WINDOW_RESET, ACT_TICK, 48'd0, '0,      1'b0, 1'b0, '0}
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]          cfg_wr_data = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [TIME_W+VW-1:0]      s_tdata = '0;
	logic [1:0]                s_tuser = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [VW-1:0]             m_tdata;
	logic [0:0]                m_tuser;

	// bench copy of the interpolator state
	logic signed [VAL_W-1:0]   cur_value [CH];
	logic signed [VAL_W-1:0]   goal_value [CH];
	logic signed [VAL_W-1:0]   error_left [CH];
	logic [TIME_W-1:0]         deadline [CH];
	logic [TIME_W-1:0]         last_tick;
	logic                      is_primed;
	logic [CFG_W-1:0]          window_setting;

	result_t                   pending_results [$];
	int                        mismatches = 0;
	int                        requests_sent = 0;
	int                        responses_checked = 0;
	int                        windows_written = 0;

	multichannel_deadline_interpolator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic signed [VAL_W-1:0] clamp_q16(longint v);
		if (v > Q_MAX) return Q_MAX[VAL_W-1:0];
		if (v < Q_MIN) return Q_MIN[VAL_W-1:0];
		return v[VAL_W-1:0];
	endfunction

	function automatic void snap_channel(int c);
		cur_value[c] = goal_value[c];
		error_left[c] = '0;
		deadline[c] = '0;
	endfunction

	function automatic void advance_channels(logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] dt;
		logic [TIME_W-1:0] left;
		logic [VAL_W-1:0]  mag;
		logic [79:0]       prod;
		logic [79:0]       den;
		logic [79:0]       quo;
		longint            e;
		longint            step;
		if (!is_primed) return;
		dt = (now > last_tick) ? now - last_tick : '0;
		last_tick = now;
		for (int c = 0; c < CH; c++) begin
			if (deadline[c] == '0) continue;
			if (now >= deadline[c]) begin
				snap_channel(c);
				continue;
			end
			left = deadline[c] - now;
			e = longint'(error_left[c]);
			mag = VAL_W'((e < 0) ? -e : e);
			prod = {48'd0, mag} * {32'd0, dt};
			den = {31'd0, {1'b0, left} + {1'b0, dt}};
			quo = (dt != '0) ? prod / den : '0;
			step = longint'(quo[63:0]);
			if (e < 0) step = -step;
			cur_value[c] = clamp_q16(longint'(cur_value[c]) + step);
			error_left[c] = clamp_q16(longint'(goal_value[c]) - longint'(cur_value[c]));
		end
	endfunction

	function automatic result_t interpolate_request(mdi_action_t act, logic [TIME_W-1:0] now,
			logic [VW-1:0] tg);
		result_t                 res;
		logic signed [VAL_W-1:0] t;
		logic [TIME_W:0]         dl;
		case (act)
			ACT_TICK: begin
				advance_channels(now);
			end
			ACT_VECTOR: begin
				if (!is_primed) begin
					for (int c = 0; c < CH; c++) begin
						cur_value[c] = signed'(tg[c*VAL_W +: VAL_W]);
						goal_value[c] = cur_value[c];
						error_left[c] = '0;
						deadline[c] = '0;
					end
					last_tick = now;
					is_primed = 1'b1;
				end else begin
					advance_channels(now);
					for (int c = 0; c < CH; c++) begin
						t = signed'(tg[c*VAL_W +: VAL_W]);
						if (t == goal_value[c]) continue;
						goal_value[c] = t;
						if (window_setting == '0) begin
							snap_channel(c);
							continue;
						end
						error_left[c] = clamp_q16(longint'(t) - longint'(cur_value[c]));
						dl = {1'b0, now} + {{(TIME_W+1-CFG_W){1'b0}}, window_setting};
						deadline[c] = dl[TIME_W] ? TIME_TOP : dl[TIME_W-1:0];
					end
				end
			end
			ACT_RESET: begin
				is_primed = 1'b0;
				for (int c = 0; c < CH; c++) deadline[c] = '0;
			end
			default: begin
			end
		endcase
		res.primed = is_primed;
		for (int c = 0; c < CH; c++) res.values[c*VAL_W +: VAL_W] = cur_value[c];
		return res;
	endfunction

	// offer one request, hold it until taken, then record what should come back
	task automatic send_request(mdi_action_t act, logic [TIME_W-1:0] now, logic [VW-1:0] tg,
			logic typed, result_t typed_res);
		result_t predicted;
		s_tvalid <= 1'b1;
		s_tdata <= {tg, now};
		s_tuser <= act;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = interpolate_request(act, now, tg);
		pending_results.push_back(typed ? typed_res : predicted);
		requests_sent++;
	endtask

	task automatic sender_gap(int idx);
		int r;
		int g;
		r = $urandom_range(0, 99);
		if ((idx % PHASE_ITEMS) >= 40 && (idx % PHASE_ITEMS) < 60) g = 0;
		else if (r < 50) g = 0;
		else if (r < 85) g = $urandom_range(1, 4);
		else if (r < 97) g = $urandom_range(5, 20);
		else g = $urandom_range(40, 150);
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// window is only changed with nothing in flight
	task automatic write_window(logic [CFG_W-1:0] w);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		window_setting = w;
		windows_written++;
	endtask

	initial begin : response_side
		int      stall_left;
		int      r;
		int      recv_cycle;
		bit      long_hold_done;
		result_t want;
		stall_left = 0;
		recv_cycle = 0;
		long_hold_done = 1'b0;
		forever begin
			@(posedge clk);
			recv_cycle++;
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("response with no request outstanding: primed %0b values %h",
						m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					responses_checked++;
					if (m_tuser[0] !== want.primed) begin
						$error("primed: expected %0b, actual %0b", want.primed, m_tuser[0]);
						mismatches++;
					end
					for (int c = 0; c < CH; c++) begin
						if (m_tdata[c*VAL_W +: VAL_W] !== want.values[c*VAL_W +: VAL_W]) begin
							$error("value_%0d: expected %h, actual %h", c,
								want.values[c*VAL_W +: VAL_W], m_tdata[c*VAL_W +: VAL_W]);
							mismatches++;
						end
					end
				end
			end
			// one long hold-off so the block backs up and stalls its input
			if (!long_hold_done && responses_checked >= 120) begin
				stall_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ((recv_cycle / 1500) % 5 == 2) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					if (r < 95) stall_left = $urandom_range(0, 2);
					else if (r < 99) stall_left = $urandom_range(3, 19);
					else stall_left = $urandom_range(29, 149);
				end
			end
		end
	end

	initial begin : request_side
		int                      r;
		int                      idx;
		logic [CFG_W-1:0]        w;
		logic [TIME_W-1:0]       now;
		logic [63:0]             wide;
		logic [VW-1:0]           tg;
		logic signed [VAL_W-1:0] t;
		mdi_action_t             act;
		for (int c = 0; c < CH; c++) begin
			cur_value[c] = '0;
			goal_value[c] = '0;
			error_left[c] = '0;
			deadline[c] = '0;
		end
		last_tick = '0;
		is_primed = 1'b0;
		window_setting = WINDOW_RESET;
		now = '0;
		idx = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].is_cfg) begin
				write_window(DIRECTED[i].cfg_val);
			end else begin
				send_request(DIRECTED[i].act, DIRECTED[i].now, DIRECTED[i].targets,
					DIRECTED[i].checked, '{DIRECTED[i].exp_primed, DIRECTED[i].exp_values});
				sender_gap(idx);
				idx++;
			end
		end
		now = 48'd1000;

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: w = CFG_W'($urandom_range(20, 200));
				1: w = 16'd1;
				2: w = 16'hffff;
				default: w = CFG_W'($urandom_range(1, 65535));
			endcase
			write_window(w);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 85) begin
					now = now + $urandom_range(0, 40);
				end else if (r < 93) begin
					now = now + $urandom_range(100, 400);
				end else if (r < 97) begin
					now = now - $urandom_range(0, 50);
				end else begin
					wide = {$urandom, $urandom};
					now = wide[TIME_W-1:0];
				end
				r = $urandom_range(0, 99);
				if (r < 55) act = ACT_TICK;
				else if (r < 93) act = ACT_VECTOR;
				else if (r < 97) act = ACT_RESET;
				else act = ACT_UNUSED;
				// mix of unchanged, nearby, extreme and arbitrary targets
				for (int c = 0; c < CH; c++) begin
					r = $urandom_range(0, 99);
					if (r < 35) begin
						t = goal_value[c];
					end else if (r < 55) begin
						t = clamp_q16(longint'(goal_value[c]) +
							longint'($urandom_range(0, 1 << 20)) - longint'(1 << 19));
					end else if (r < 70) begin
						case ($urandom_range(0, 2))
							0: t = Q_MAX[VAL_W-1:0];
							1: t = Q_MIN[VAL_W-1:0];
							default: t = '0;
						endcase
					end else begin
						t = $urandom;
					end
					tg[c*VAL_W +: VAL_W] = t;
				end
				send_request(act, now, tg, 1'b0, '0);
				sender_gap(idx);
				idx++;
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent (%0d directed), %0d responses checked, %0d window writes",
			requests_sent, requests_sent - RANDOM_PHASES * PHASE_ITEMS, responses_checked,
			windows_written);
		$display("covered ticks, vectors, resets, unused requests and backward time steps");
		if (mismatches == 0) begin
			$display("multichannel_deadline_interpolator_tb passed");
		end else begin
			$display("multichannel_deadline_interpolator_tb failed");
		end
		$finish;
	end

	initial begin : watchdog
		#20000000;
		$display("multichannel_deadline_interpolator_tb failed");
		$finish;
	end

endmodule
